// File: rtl/core/tlrc_pkg.sv
`default_nettype none
package tlrc_pkg;
  localparam int ENTRIES_DEF = 16;
  localparam int MAX_PACKET_DEF = 512;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;
  // ceil(2^36 / 1000): exact quotient for 26-bit dividends
  localparam logic [26:0] MS_RECIP = 27'd68719477;

  localparam logic [1:0] FUNC_PUT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_EXPIRE = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] name_key;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [63:0] now_ms;
    logic [31:0] ttl_seconds;
    logic [15:0] packet_length;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [3:0]  slot;
    logic        evicted;
    logic [31:0] elapsed_seconds;
    logic [4:0]  valid_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] typ;
    logic [15:0] cls;
    logic [63:0] stored;
    logic [63:0] expiry;
    logic [63:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

// File: rtl/core/ttl_lru_response_cache.sv
// Tag table of a DNS response cache, fully associative over ENTRIES slots held in one
// synchronous memory read one entry per cycle. One command at a time: busy is high from
// the accepting edge until the result strobe, and the receiver cannot stall results.
// A put runs an expiry sweep pass, then a match/victim pass, then a write; a lookup runs
// a match pass, and on a hit a write-back, then a reciprocal divider from milliseconds
// to seconds; an expire runs a sweep pass. Rejected puts and the unused code go straight
// to the result strobe. The memory read port and the scan counter set the rate.
`default_nettype none
module ttl_lru_response_cache
  import tlrc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_DIV = 4'd4;
  localparam logic [3:0] S_DONE = 4'd5;
  localparam logic [3:0] S_MULT = 4'd6;

  entry_t mem [ENTRIES];
  entry_t rd;
  logic [ENTRIES-1:0] live;
  logic [CW-1:0] live_count;
  logic [63:0] use_counter;

  logic [3:0] state;
  req_t r;
  logic [IW:0] addr;
  logic [IW-1:0] prev;
  logic rd_ok;
  logic found, free_found, best_set;
  logic [IW-1:0] hit, free_idx, best;
  logic [63:0] best_stamp;
  entry_t hit_ent;
  logic wr_en;
  logic [IW-1:0] wr_idx;
  entry_t wr_data;
  logic [63:0] ttl_ms;
  logic [63:0] dividend;
  logic [9:0] rem;
  logic [2:0] dcnt;
  logic [15:0] qdig;
  logic [31:0] quo;

  logic [IW-1:0] addr_i;
  assign addr_i = addr[IW-1:0];
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    rd <= mem[addr_i];
    if (wr_en) mem[wr_idx] <= wr_data;
  end

  logic expired;
  logic matched;
  assign expired = live[prev] && (rd.expiry <= r.now_ms);
  assign matched = live[prev] && rd.key == r.name_key && rd.typ == r.query_type &&
                   rd.cls == r.query_class;

  logic [25:0] div_val;
  logic [52:0] div_prod;
  assign div_val = {rem, dividend[63:48]};
  assign div_prod = 53'(div_val) * 53'(MS_RECIP);

  always_ff @(posedge clk) begin
    wr_en <= !rst && (state == S_WRITE);
    done <= !rst && (state == S_DONE);
    if (rst) begin
      state <= S_IDLE;
      live <= '0;
      live_count <= '0;
      use_counter <= '0;
      rd_ok <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            addr <= '0;
            rd_ok <= 1'b0;
            found <= 1'b0;
            free_found <= 1'b0;
            best_set <= 1'b0;
            rsp <= '0;
            ttl_ms <= 64'(req.ttl_seconds) * 64'(MS_PER_SEC);
            if (req.func == FUNC_PUT && req.ttl_seconds != '0 &&
                32'(req.packet_length) <= 32'(MAX_PACKET)) state <= S_SWEEP;
            else if (req.func == FUNC_EXPIRE) state <= S_SWEEP;
            else if (req.func == FUNC_LOOKUP) state <= S_SCAN;
            else state <= S_DONE;
          end
        end
        S_SWEEP: begin
          prev <= addr_i;
          if (rd_ok && expired) begin
            live[prev] <= 1'b0;
            live_count <= live_count - 1'b1;
          end
          if (rd_ok && addr == (IW+1)'(ENTRIES)) begin
            rd_ok <= 1'b0;
            addr <= '0;
            state <= (r.func == FUNC_EXPIRE) ? S_DONE : S_SCAN;
          end else begin
            rd_ok <= (addr < (IW+1)'(ENTRIES));
            if (addr < (IW+1)'(ENTRIES)) addr <= addr + 1'b1;
          end
        end
        S_SCAN: begin
          prev <= addr_i;
          if (rd_ok) begin
            if (expired) begin
              live[prev] <= 1'b0;
              live_count <= live_count - 1'b1;
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx <= prev;
              end
            end else if (matched) begin
              found <= 1'b1;
              hit <= prev;
              hit_ent <= rd;
            end else if (!live[prev]) begin
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx <= prev;
              end
            end else if (!best_set || rd.stamp < best_stamp) begin
              best_set <= 1'b1;
              best <= prev;
              best_stamp <= rd.stamp;
            end
          end
          if (rd_ok && !expired && matched) begin
            rd_ok <= 1'b0;
            state <= S_WRITE;
          end else if (rd_ok && addr == (IW+1)'(ENTRIES)) begin
            rd_ok <= 1'b0;
            state <= (r.func == FUNC_PUT) ? S_WRITE : S_DONE;
          end else begin
            rd_ok <= (addr < (IW+1)'(ENTRIES));
            if (addr < (IW+1)'(ENTRIES)) addr <= addr + 1'b1;
          end
        end
        S_WRITE: begin
          if (r.func == FUNC_PUT) begin
            wr_data.key <= r.name_key;
            wr_data.typ <= r.query_type;
            wr_data.cls <= r.query_class;
            wr_data.stored <= r.now_ms;
            wr_data.expiry <= r.now_ms + ttl_ms;
            wr_data.stamp <= use_counter + 64'd1;
            use_counter <= use_counter + 64'd1;
            rsp.success <= 1'b1;
            if (found) begin
              wr_idx <= hit;
              rsp.slot <= 4'(hit);
            end else if (free_found) begin
              wr_idx <= free_idx;
              rsp.slot <= 4'(free_idx);
              live[free_idx] <= 1'b1;
              live_count <= live_count + 1'b1;
            end else begin
              wr_idx <= best;
              rsp.slot <= 4'(best);
              rsp.evicted <= 1'b1;
            end
            state <= S_MULT;
          end else begin
            wr_idx <= hit;
            wr_data <= '{key: hit_ent.key, typ: hit_ent.typ, cls: hit_ent.cls,
                         stored: hit_ent.stored, expiry: hit_ent.expiry,
                         stamp: use_counter + 64'd1};
            use_counter <= use_counter + 64'd1;
            rsp.success <= 1'b1;
            rsp.slot <= 4'(hit);
            dividend <= r.now_ms - hit_ent.stored;
            rem <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_MULT: begin
          state <= S_DONE;
        end
        S_DIV: begin
          if (!dcnt[0]) begin
            qdig <= div_prod[51:36];
          end else begin
            rem <= 10'(div_val - 26'(qdig) * 26'(MS_PER_SEC));
            quo <= {quo[15:0], qdig};
            dividend <= {dividend[47:0], 16'd0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 3'd7) state <= S_DONE;
        end
        S_DONE: begin
          rsp.valid_count <= 5'(live_count);
          if (r.func == FUNC_LOOKUP && rsp.success) rsp.elapsed_seconds <= quo;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: tb/ttl_lru_response_cache_tb.sv
`default_nettype none
module ttl_lru_response_cache_tb
  import tlrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int PKT_MAX = 512;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  ttl_lru_response_cache dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  logic        tag_live [NSLOT];
  logic [63:0] tag_key [NSLOT];
  logic [15:0] tag_typ [NSLOT];
  logic [15:0] tag_cls [NSLOT];
  logic [63:0] tag_stored [NSLOT];
  logic [63:0] tag_expiry [NSLOT];
  logic [63:0] tag_stamp [NSLOT];
  logic [63:0] stamp_ctr;
  int          live_total;

  rsp_t pending_rsp [$];
  int   errors = 0;
  int   burst_left = 0;

  // shared key pool keeps hits and rewrites frequent
  logic [63:0] key_pool [6];
  logic [63:0] clock_ms;

  function automatic bit is_stale(int i, logic [63:0] now);
    return tag_live[i] && tag_expiry[i] <= now;
  endfunction

  function automatic void drop_tag(int i);
    tag_live[i] = 1'b0;
    if (live_total > 0) live_total--;
  endfunction

  function automatic void sweep_stale(logic [63:0] now);
    for (int i = 0; i < NSLOT; i++) if (is_stale(i, now)) drop_tag(i);
  endfunction

  function automatic int find_tag(req_t r);
    for (int i = 0; i < NSLOT; i++) begin
      if (is_stale(i, r.now_ms)) begin
        drop_tag(i);
        continue;
      end
      if (tag_live[i] && tag_key[i] == r.name_key && tag_typ[i] == r.query_type &&
          tag_cls[i] == r.query_class) return i;
    end
    return NSLOT;
  endfunction

  function automatic rsp_t predict_cache(req_t r);
    rsp_t o;
    int s;
    int best;
    logic [63:0] diff;
    o = '0;
    if (r.func == FUNC_PUT) begin
      if (r.ttl_seconds != 0 && r.packet_length <= PKT_MAX) begin
        sweep_stale(r.now_ms);
        s = find_tag(r);
        if (s >= NSLOT) begin
          s = NSLOT;
          for (int i = 0; i < NSLOT; i++)
            if (!tag_live[i] && s == NSLOT) s = i;
          if (s == NSLOT) begin
            best = 0;
            for (int i = 1; i < NSLOT; i++) if (tag_stamp[i] < tag_stamp[best]) best = i;
            s = best;
          end
          if (tag_live[s]) o.evicted = 1'b1;
          else live_total++;
        end
        tag_live[s] = 1'b1;
        tag_key[s] = r.name_key;
        tag_typ[s] = r.query_type;
        tag_cls[s] = r.query_class;
        tag_stored[s] = r.now_ms;
        tag_expiry[s] = r.now_ms + 64'(r.ttl_seconds) * 64'd1000;
        stamp_ctr++;
        tag_stamp[s] = stamp_ctr;
        o.success = 1'b1;
        o.slot = s[3:0];
      end
    end else if (r.func == FUNC_LOOKUP) begin
      s = find_tag(r);
      if (s < NSLOT) begin
        diff = r.now_ms - tag_stored[s];
        o.elapsed_seconds = 32'(diff / 64'd1000);
        stamp_ctr++;
        tag_stamp[s] = stamp_ctr;
        o.success = 1'b1;
        o.slot = s[3:0];
      end
    end else if (r.func == FUNC_EXPIRE) begin
      sweep_stale(r.now_ms);
    end
    o.valid_count = live_total[4:0];
    return o;
  endfunction

  task automatic send_cmd(req_t r);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(predict_cache(r));
    start <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.success !== e.success) begin
          $error("success exp %0h got %0h", e.success, rsp.success); errors++;
        end
        if (rsp.slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, rsp.slot); errors++;
        end
        if (rsp.evicted !== e.evicted) begin
          $error("evicted exp %0h got %0h", e.evicted, rsp.evicted); errors++;
        end
        if (rsp.elapsed_seconds !== e.elapsed_seconds) begin
          $error("elapsed_seconds exp %0h got %0h", e.elapsed_seconds,
                 rsp.elapsed_seconds);
          errors++;
        end
        if (rsp.valid_count !== e.valid_count) begin
          $error("valid_count exp %0d got %0d", e.valid_count, rsp.valid_count); errors++;
        end
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] f, logic [63:0] k, logic [15:0] t,
                                  logic [15:0] c, logic [63:0] now, logic [31:0] ttl,
                                  logic [15:0] len);
    req_t r;
    r.func = f; r.name_key = k; r.query_type = t; r.query_class = c;
    r.now_ms = now; r.ttl_seconds = ttl; r.packet_length = len;
    return r;
  endfunction

  task automatic test_directed();
    send_cmd(mk_req(FUNC_LOOKUP, 64'd1, 16'd1, 16'd1, 64'd0, 32'd0, 16'd0));
    send_cmd(mk_req(FUNC_PUT, 64'd1, 16'd1, 16'd1, 64'd100, 32'd0, 16'd10));
    send_cmd(mk_req(FUNC_PUT, 64'd1, 16'd1, 16'd1, 64'd100, 32'd5, 16'd513));
    send_cmd(mk_req(FUNC_PUT, 64'd1, 16'd1, 16'd1, 64'd100, 32'd5, 16'd512));
    send_cmd(mk_req(FUNC_PUT, '1, '1, '1, 64'd100, '1, 16'd0));
    send_cmd(mk_req(FUNC_LOOKUP, 64'd1, 16'd1, 16'd1, 64'd3100, 32'd0, 16'hffff));
    send_cmd(mk_req(FUNC_LOOKUP, '1, '1, '1, 64'd50, '1, '1));
    send_cmd(mk_req(FUNC_PUT, 64'd1, 16'd1, 16'd1, 64'd4000, 32'd9, 16'd1));
    send_cmd(mk_req(FUNC_UNUSED, '1, '1, '1, '1, '1, '1));
    send_cmd(mk_req(FUNC_PUT, 64'd7, 16'd2, 16'd3, 64'hffff_ffff_ffff_ff00, 32'd1, 16'd4));
    send_cmd(mk_req(FUNC_EXPIRE, '0, '0, '0, 64'd10000, '0, '0));
    send_cmd(mk_req(FUNC_EXPIRE, '0, '0, '0, '1, '0, '0));
    for (int i = 0; i < 18; i++)
      send_cmd(mk_req(FUNC_PUT, 64'(i), 16'd1, 16'd1, 64'd20000, 32'd100, 16'd64));
  endtask

  task automatic test_random();
    req_t r;
    int sel;
    for (int i = 0; i < 6; i++) key_pool[i] = {$urandom, $urandom};
    clock_ms = 64'd1000000;
    for (int n = 0; n < 1850; n++) begin
      sel = $urandom_range(0, 99);
      clock_ms += 64'($urandom_range(0, 3000));
      if ($urandom_range(0, 60) == 0) clock_ms -= 64'($urandom_range(0, 50000));
      r.name_key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                : key_pool[$urandom_range(0, 5)];
      r.query_type = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
      r.query_class = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1;
      r.now_ms = ($urandom_range(0, 80) == 0) ? {$urandom, $urandom} : clock_ms;
      r.ttl_seconds = ($urandom_range(0, 15) == 0) ? $urandom : 32'($urandom_range(0, 20));
      r.packet_length = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, PKT_MAX));
      if (sel < 45) r.func = FUNC_PUT;
      else if (sel < 88) r.func = FUNC_LOOKUP;
      else if (sel < 96) r.func = FUNC_EXPIRE;
      else r.func = FUNC_UNUSED;
      send_cmd(r);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tag_live[i] = 1'b0; tag_key[i] = '0; tag_typ[i] = '0; tag_cls[i] = '0;
      tag_stored[i] = '0; tag_expiry[i] = '0; tag_stamp[i] = '0;
    end
    stamp_ctr = '0;
    live_total = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: ttl_lru_response_cache.f
rtl/core/tlrc_pkg.sv
rtl/core/ttl_lru_response_cache.sv
tb/ttl_lru_response_cache_tb.sv
